/* hdl/mh2bs_pkg.sv */
// Shared constants and types for the MurmurHash2 byte-stream hasher.
package mh2bs_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned TailW = 24;
  localparam int unsigned CntW  = 2;

  localparam logic [HashW-1:0] MIX_MUL     = 32'h5bd1_e995;
  localparam int unsigned      MIX_SHIFT   = 24;
  localparam int unsigned      FIN_SHIFT_A = 13;
  localparam int unsigned      FIN_SHIFT_B = 15;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    OP_WORD = 2'd0,  // k * M
    OP_ACC  = 2'd1,  // h * M
    OP_TAIL = 2'd2,  // (h ^ tail) * M
    OP_FIN  = 2'd3   // (h ^ (h >> 13)) * M
  } op_sel_e;

endpackage

/* hdl/murmurhash2_byte_stream_top.sv */
// Top level of the MurmurHash2 byte-stream hasher: sequencer and state registers.
// A byte that does not complete a word is only stored in the tail register; one that completes
// a word stalls the input while the single shared multiplier runs k*M, k*M and h*M in turn.
// A last item adds tail multiply, finalization multiply and output load, delayed while
// an earlier hash still waits; the hash is then held at the output while new bytes arrive.
// Reset is asynchronous and active low; it clears the hash accumulator state and the output valid flag.
module murmurhash2_byte_stream_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic [mh2bs_pkg::HashW-1:0]   message_length_i,
  input  logic                          first_i,
  input  logic                          last_i,
  input  logic                          empty_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mh2bs_pkg::HashW-1:0]   hash_value_o
);
  import mh2bs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_MH,
    ST_TAIL,
    ST_FIN1,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [HashW-1:0] acc_q, acc_d;
  logic [HashW-1:0] word_q, word_d;
  logic [TailW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [HashW-1:0] hash_q, hash_d;

  op_sel_e          op_sel;
  logic [HashW-1:0] prod;
  logic             in_fire;
  logic [HashW-1:0] acc_base;
  logic [TailW-1:0] tail_base;
  logic [CntW-1:0]  cnt_base;
  logic             out_free;

  mh2bs_mul_unit u_mul (
    .op_sel_i (op_sel),
    .acc_i    (acc_q),
    .word_i   (word_q),
    .tail_i   (tail_q),
    .prod_o   (prod)
  );

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_fire      = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  // A first item restarts the message from the sampled length.
  assign acc_base  = first_i ? message_length_i : acc_q;
  assign tail_base = first_i ? '0 : tail_q;
  assign cnt_base  = first_i ? '0 : cnt_q;

  always_comb begin
    unique case (state_q)
      ST_K1, ST_K2: op_sel = OP_WORD;
      ST_MH:        op_sel = OP_ACC;
      ST_TAIL:      op_sel = OP_TAIL;
      ST_FIN1:      op_sel = OP_FIN;
      default:      op_sel = OP_ACC;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    word_d      = word_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          acc_d  = acc_base;
          tail_d = tail_base;
          cnt_d  = cnt_base;
          last_d = last_i;
          if (!empty_req_i && cnt_base == CntW'(3)) begin
            word_d  = {data_byte_i, tail_base};
            tail_d  = '0;
            cnt_d   = '0;
            state_d = ST_K1;
          end else begin
            if (!empty_req_i) begin
              unique case (cnt_base)
                2'd0:    tail_d = {tail_base[23:8], data_byte_i};
                2'd1:    tail_d = {tail_base[23:16], data_byte_i, tail_base[7:0]};
                default: tail_d = {data_byte_i, tail_base[15:0]};
              endcase
              cnt_d = cnt_base + CntW'(1);
            end
            if (last_i) begin
              state_d = ST_TAIL;
            end
          end
        end
      end
      ST_K1: begin
        word_d  = prod ^ (prod >> MIX_SHIFT);
        state_d = ST_K2;
      end
      ST_K2: begin
        word_d  = prod;
        state_d = ST_MH;
      end
      ST_MH: begin
        acc_d   = prod ^ word_q;
        state_d = last_q ? ST_TAIL : ST_IDLE;
      end
      ST_TAIL: begin
        // Pending tail bytes are folded in only when there are any.
        if (cnt_q != '0) begin
          acc_d = prod;
        end
        state_d = ST_FIN1;
      end
      ST_FIN1: begin
        acc_d   = prod;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          hash_d      = acc_q ^ (acc_q >> FIN_SHIFT_B);
          out_valid_d = 1'b1;
          acc_d       = '0;
          tail_d      = '0;
          cnt_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    hash_q <= hash_d;
  end

endmodule

/* hdl/mh2bs_mul_unit.sv */
// Shared multiply-by-constant unit with operand selection.
module mh2bs_mul_unit (
  input  mh2bs_pkg::op_sel_e                op_sel_i,
  input  logic [mh2bs_pkg::HashW-1:0]       acc_i,
  input  logic [mh2bs_pkg::HashW-1:0]       word_i,
  input  logic [mh2bs_pkg::TailW-1:0]       tail_i,
  output logic [mh2bs_pkg::HashW-1:0]       prod_o
);
  import mh2bs_pkg::*;

  logic [HashW-1:0] operand;
  logic [2*HashW-1:0] full_prod;

  always_comb begin
    unique case (op_sel_i)
      OP_WORD: operand = word_i;
      OP_ACC:  operand = acc_i;
      OP_TAIL: operand = acc_i ^ {{(HashW-TailW){1'b0}}, tail_i};
      OP_FIN:  operand = acc_i ^ (acc_i >> FIN_SHIFT_A);
      default: operand = acc_i;
    endcase
  end

  // Only the low word of the product is kept, as in 32-bit modular arithmetic.
  assign full_prod = operand * MIX_MUL;
  assign prod_o    = full_prod[HashW-1:0];

endmodule
